### rtl/core/nbsz_pkg.sv
// Shared constants, codes and types for the nested box safety zoner.
`timescale 1ns / 1ps

package nbsz_pkg;

	// Point coordinate width (signed, mm)
	localparam int COORD_BITS = 16;

	// Configuration field widths
	localparam int EXT_W    = 15;
	localparam int MARGIN_W = 32;
	localparam int MHALF_W  = MARGIN_W / 2;
	localparam int HOLD_W   = 16;
	localparam int CALM_W   = 17;

	// Compare width: holds a coordinate and -(extent + margin) with sign
	localparam int CMP_W = ((COORD_BITS > MHALF_W + 1) ? COORD_BITS : MHALF_W + 1) + 2;

	// Stream widths
	localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = 8;

	// Configuration port widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Reset values of the configuration registers
	localparam logic [EXT_W-1:0]    RST_REAR  = EXT_W'(500);
	localparam logic [EXT_W-1:0]    RST_FRONT = EXT_W'(1500);
	localparam logic [EXT_W-1:0]    RST_HALF  = EXT_W'(400);
	localparam logic [HOLD_W-1:0]   RST_HOLD  = HOLD_W'(5);

	// Zone and safety level share one ordering: none/safe < slow < creep < stop
	typedef enum logic [1:0] {
		ZONE_NONE  = 2'd0,
		ZONE_SLOW  = 2'd1,
		ZONE_CREEP = 2'd2,
		ZONE_STOP  = 2'd3
	} zone_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REAR_EXTENT   = 3'd0,
		REG_FRONT_EXTENT  = 3'd1,
		REG_HALF_WIDTH    = 3'd2,
		REG_STOP_MARGINS  = 3'd3,
		REG_CREEP_MARGINS = 3'd4,
		REG_SLOW_MARGINS  = 3'd5,
		REG_HOLD_COUNT    = 3'd6
	} cfg_reg_t;

	// Vehicle geometry shared by the box checks
	typedef struct packed {
		logic [EXT_W-1:0] rear;
		logic [EXT_W-1:0] front;
		logic [EXT_W-1:0] half;
	} geom_t;

	// Item flags handed to the level controller
	typedef struct packed {
		logic has_point;
		logic last;
	} item_flags_t;

	// One result beat
	typedef struct packed {
		zone_t zone;
		zone_t level;
	} result_t;

endpackage

### rtl/core/nbsz_box_check.sv
// Inclusive point-in-box test for one grown vehicle rectangle.
`timescale 1ns / 1ps

module nbsz_box_check (
	input  logic signed [nbsz_pkg::CMP_W-1:0]   x,
	input  logic signed [nbsz_pkg::CMP_W-1:0]   y,
	input  nbsz_pkg::geom_t                     geom,
	input  logic        [nbsz_pkg::MARGIN_W-1:0] margins,
	output logic                                hit
);

	logic signed [nbsz_pkg::CMP_W-1:0] mx, my;
	logic signed [nbsz_pkg::CMP_W-1:0] rear_e, front_e, half_e;
	logic signed [nbsz_pkg::CMP_W-1:0] xlo, xhi, ylo, yhi;

	// zero-extend unsigned fields into the signed compare width
	assign mx      = signed'(nbsz_pkg::CMP_W'(margins[nbsz_pkg::MHALF_W-1:0]));
	assign my      = signed'(nbsz_pkg::CMP_W'(margins[nbsz_pkg::MARGIN_W-1:nbsz_pkg::MHALF_W]));
	assign rear_e  = signed'(nbsz_pkg::CMP_W'(geom.rear));
	assign front_e = signed'(nbsz_pkg::CMP_W'(geom.front));
	assign half_e  = signed'(nbsz_pkg::CMP_W'(geom.half));

	// box bounds
	assign xlo = -(rear_e + mx);
	assign xhi = front_e + mx;
	assign ylo = -(half_e + my);
	assign yhi = half_e + my;

	assign hit = (x >= xlo) && (x <= xhi) && (y >= ylo) && (y <= yhi);

endmodule

### rtl/core/nbsz_level_ctl.sv
// Per-scan zone latch and safety level hysteresis.
`timescale 1ns / 1ps

module nbsz_level_ctl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  nbsz_pkg::item_flags_t             flags,
	input  nbsz_pkg::zone_t                   hit_zone,
	input  logic [nbsz_pkg::HOLD_W-1:0]       hold_count,
	output nbsz_pkg::result_t                 result
);

	nbsz_pkg::zone_t                   level_q, pending_q;
	logic                              decided_q;
	logic [nbsz_pkg::CALM_W-1:0]       calm_q;

	logic                              hit;
	logic                              decided_n;
	nbsz_pkg::zone_t                   pending_n;
	nbsz_pkg::zone_t                   req;
	logic                              do_req;
	nbsz_pkg::zone_t                   level_n;
	logic [nbsz_pkg::CALM_W-1:0]       calm_n;
	logic [nbsz_pkg::CALM_W-1:0]       calm_inc;

	// first box hit of the scan wins
	assign hit       = flags.has_point && !decided_q && (hit_zone != nbsz_pkg::ZONE_NONE);
	assign decided_n = decided_q || hit;
	assign pending_n = hit ? hit_zone : pending_q;

	// request at end of scan; a clear scan requests safe only when not safe
	assign req      = decided_n ? pending_n : nbsz_pkg::ZONE_NONE;
	assign do_req   = decided_n || (level_q != nbsz_pkg::ZONE_NONE);
	assign calm_inc = calm_q + nbsz_pkg::CALM_W'(1);

	always_comb begin
		level_n = level_q;
		calm_n  = calm_q;
		if (do_req) begin
			if (req > level_q) begin
				level_n = req;
				calm_n  = '0;
			end else if (req < level_q) begin
				if (calm_inc > nbsz_pkg::CALM_W'(hold_count)) begin
					level_n = nbsz_pkg::zone_t'(level_q - 2'd1);
					calm_n  = '0;
				end else begin
					calm_n = calm_inc;
				end
			end else begin
				calm_n = '0;
			end
		end
	end

	assign result.level = level_n;
	assign result.zone  = req;

	// state update on each item leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= nbsz_pkg::ZONE_STOP;
			calm_q    <= '0;
			decided_q <= 1'b0;
			pending_q <= nbsz_pkg::ZONE_NONE;
		end else if (advance) begin
			if (flags.last) begin
				level_q   <= level_n;
				calm_q    <= calm_n;
				decided_q <= 1'b0;
				pending_q <= nbsz_pkg::ZONE_NONE;
			end else begin
				decided_q <= decided_n;
				pending_q <= pending_n;
			end
		end
	end

endmodule

### rtl/core/nested_box_safety_zoner_unit.sv
// Top level of the nested box safety zoner: config, input register, result register.
//
//  channel  | dir | beat contents
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | tdata: point_x, point_y; tuser: has_point; tlast: last_of_scan
//  m_axis   | out | tdata: vehicle_level, scan_zone; one beat per scan end
//  cfg      | in  | cfg_index selects register, cfg_data is the value
//
//  One point per cycle: an input register feeds three box compares and the
//  level update, whose scan-end result is written into the result register.
//  Reset clears the level to stop, the calm counter and the scan latch, and
//  loads the default geometry. cfg_ready is always high.
//  A scan-ending beat in the input register waits only while the result slot
//  is full and m_axis_tready is low; s_axis_tready is low for those cycles.
`timescale 1ns / 1ps

module nested_box_safety_zoner_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [nbsz_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // point_x, point_y
	input  logic                                s_axis_tuser,   // has_point
	input  logic                                s_axis_tlast,   // last_of_scan
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [nbsz_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // vehicle_level, scan_zone, pad
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nbsz_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nbsz_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// configuration registers
	nbsz_pkg::geom_t                    geom_q;
	logic [nbsz_pkg::MARGIN_W-1:0]      stop_m_q, creep_m_q, slow_m_q;
	logic [nbsz_pkg::HOLD_W-1:0]        hold_q;

	// input register
	logic                               valid_s1;
	logic signed [nbsz_pkg::COORD_BITS-1:0] x_s1, y_s1;
	nbsz_pkg::item_flags_t              flags_s1;

	// result register
	logic                               out_valid_q;
	nbsz_pkg::result_t                  out_q;

	logic                               advance;
	logic signed [nbsz_pkg::CMP_W-1:0]  x_ext, y_ext;
	logic                               hit_stop, hit_creep, hit_slow;
	nbsz_pkg::zone_t                    hit_zone;
	nbsz_pkg::result_t                  result;

	assign cfg_ready = 1'b1;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.rear  <= nbsz_pkg::RST_REAR;
			geom_q.front <= nbsz_pkg::RST_FRONT;
			geom_q.half  <= nbsz_pkg::RST_HALF;
			stop_m_q     <= '0;
			creep_m_q    <= '0;
			slow_m_q     <= '0;
			hold_q       <= nbsz_pkg::RST_HOLD;
		end else if (cfg_valid) begin
			case (nbsz_pkg::cfg_reg_t'(cfg_index))
				nbsz_pkg::REG_REAR_EXTENT:   geom_q.rear  <= cfg_data[nbsz_pkg::EXT_W-1:0];
				nbsz_pkg::REG_FRONT_EXTENT:  geom_q.front <= cfg_data[nbsz_pkg::EXT_W-1:0];
				nbsz_pkg::REG_HALF_WIDTH:    geom_q.half  <= cfg_data[nbsz_pkg::EXT_W-1:0];
				nbsz_pkg::REG_STOP_MARGINS:  stop_m_q     <= cfg_data[nbsz_pkg::MARGIN_W-1:0];
				nbsz_pkg::REG_CREEP_MARGINS: creep_m_q    <= cfg_data[nbsz_pkg::MARGIN_W-1:0];
				nbsz_pkg::REG_SLOW_MARGINS:  slow_m_q     <= cfg_data[nbsz_pkg::MARGIN_W-1:0];
				nbsz_pkg::REG_HOLD_COUNT:    hold_q       <= cfg_data[nbsz_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 moves on unless it ends a scan and the result slot is full with m_axis_tready low
	assign advance       = valid_s1 && (!flags_s1.last || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			x_s1               <= signed'(s_axis_tdata[nbsz_pkg::COORD_BITS-1:0]);
			y_s1               <= signed'(s_axis_tdata[2*nbsz_pkg::COORD_BITS-1:nbsz_pkg::COORD_BITS]);
			flags_s1.has_point <= s_axis_tuser;
			flags_s1.last      <= s_axis_tlast;
		end
	end

	// box compares, stop first
	assign x_ext = nbsz_pkg::CMP_W'(x_s1);
	assign y_ext = nbsz_pkg::CMP_W'(y_s1);

	nbsz_box_check u_stop (
		.x(x_ext), .y(y_ext), .geom(geom_q), .margins(stop_m_q), .hit(hit_stop)
	);
	nbsz_box_check u_creep (
		.x(x_ext), .y(y_ext), .geom(geom_q), .margins(creep_m_q), .hit(hit_creep)
	);
	nbsz_box_check u_slow (
		.x(x_ext), .y(y_ext), .geom(geom_q), .margins(slow_m_q), .hit(hit_slow)
	);

	always_comb begin
		if (hit_stop)       hit_zone = nbsz_pkg::ZONE_STOP;
		else if (hit_creep) hit_zone = nbsz_pkg::ZONE_CREEP;
		else if (hit_slow)  hit_zone = nbsz_pkg::ZONE_SLOW;
		else                hit_zone = nbsz_pkg::ZONE_NONE;
	end

	nbsz_level_ctl u_level (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.flags      (flags_s1),
		.hit_zone   (hit_zone),
		.hold_count (hold_q),
		.result     (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && flags_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && flags_s1.last) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = nbsz_pkg::OUT_DATA_W'({out_q.zone, out_q.level});

endmodule

### rtl/core/nbsz_checker.sv
// Port-level checks for the nested box safety zoner, bound to the top level.
`timescale 1ns / 1ps

module nbsz_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tready,
	input  logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic [nbsz_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat dropped or changed while stalled");

	// input backpressure only comes from a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// the level never sits below the zone the scan requested
	a_level_ge_zone: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] >= m_axis_tdata[3:2])
		else $error("vehicle level below requested zone");

	// pad bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[nbsz_pkg::OUT_DATA_W-1:4] == '0)
		else $error("result pad bits not zero");

endmodule

bind nested_box_safety_zoner_unit nbsz_checker u_nbsz_checker (.*);
